FILE: design/stc_pkg.sv
package stc_pkg;

   // Fixed widths of the request and response fields.
   localparam int SYMBOL_W   = 4;
   localparam int REFPOS_W   = 13;
   localparam int POS_W      = 12;
   localparam int COUNT_W    = 12;
   localparam int SHIFT_W    = 12;
   localparam int SYMUSE_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Request modes.
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_REF     = 2'd1;
   localparam logic [1:0] MODE_READ    = 2'd2;
   localparam logic [1:0] MODE_RESTART = 2'd3;

   // Response kinds.
   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_COUNT  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_FULL    = 2'd1;
   localparam logic [1:0] ERR_SYMBOL  = 2'd2;
   localparam logic [1:0] ERR_POSITION = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CONTEXT_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_DEPTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_IN_USE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REF1,
      ST_REF2,
      ST_BUMP,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SYMBOL_W-1:0] symbol;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
      logic [1:0]          error;
   } result_type;

   function automatic result_type make_result(logic [1:0] kind, logic [SYMBOL_W-1:0] symbol,
                                              logic [POS_W-1:0] position,
                                              logic [COUNT_W-1:0] count, logic [1:0] error);
      result_type r;
      r.kind     = kind;
      r.symbol   = symbol;
      r.position = position;
      r.count    = count;
      r.error    = error;
      return r;
   endfunction

endpackage

FILE: design/symbol_transition_counter.sv
// Symbol transition counter.
// Requests arrive on the req_ channel (valid/stall) and carry a mode: load a
// symbol, give a reference position, read and clear one count, or restart the
// sequence. At most one response per request leaves on the rsp_ channel
// (valid/stall): a position record, a count readout or an error report.
// Configuration registers are written over the csr_ channel (valid/ready),
// which is always ready; write them only while no request is in flight.
// A load, restart, rejected request or readout error ends in ST_IDLE; a plain
// load that counts a transition goes on to ST_BUMP, a count readout to
// ST_READ. A reference reads the context symbol, then the follower if that
// lies inside, both via the one symbol read port, and only then bumps a count.
// A response is registered and appears the cycle after it is decided.
// A new request is taken only while the response register is empty or being
// emptied, so a stalled receiver holds off the request side after one
// response. After reset every entry of the count memory is cleared in turn,
// during which req_stall stays high; configuration writes are taken during
// that pass.
module symbol_transition_counter #(
   parameter int MAX_LEN     = 4096,
   parameter int MAX_SYMBOLS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [stc_pkg::SYMBOL_W-1:0]    req_symbol,
   input  logic [stc_pkg::REFPOS_W-1:0]    req_reference_position,
   input  logic [stc_pkg::SYMBOL_W-1:0]    req_row,
   input  logic [stc_pkg::SYMBOL_W-1:0]    req_col,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_out_kind,
   output logic [stc_pkg::SYMBOL_W-1:0]    rsp_out_symbol,
   output logic [stc_pkg::POS_W-1:0]       rsp_out_position,
   output logic [stc_pkg::COUNT_W-1:0]     rsp_out_count,
   output logic [1:0]                      rsp_out_error,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import stc_pkg::*;

   localparam int LEN_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LENCNT_W  = $clog2(MAX_LEN + 1);
   localparam int CNT_DEPTH = MAX_SYMBOLS * MAX_SYMBOLS;
   localparam int CIDX_W    = $clog2(CNT_DEPTH);

   // Memories and their registered read data.
   logic [SYMBOL_W-1:0] sym_store [MAX_LEN];
   logic [COUNT_W-1:0]  cnt_store [CNT_DEPTH];
   logic [SYMBOL_W-1:0] sym_rd_ff;
   logic [COUNT_W-1:0]  cnt_rd_ff;

   // Control and datapath registers.
   state_type           state_ff, state_in;
   logic [LENCNT_W-1:0] len_ff, len_in;
   logic [SYMBOL_W-1:0] prev_ff, prev_in;
   logic [LEN_W-1:0]    ctx_pos_ff, ctx_pos_in;
   logic [LEN_W-1:0]    end_addr_ff, end_addr_in;
   logic                end_ok_ff, end_ok_in;
   logic [SYMBOL_W-1:0] ctx_sym_ff, ctx_sym_in;
   logic [CIDX_W-1:0]   clr_ff, clr_in;
   logic [CIDX_W-1:0]   cidx_ff, cidx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   // Configuration registers.
   logic                context_mode_ff;
   logic [SHIFT_W-1:0]  shift_depth_ff;
   logic [SYMUSE_W-1:0] symbols_in_use_ff;

   // Memory port controls.
   logic                sym_we;
   logic [LEN_W-1:0]    sym_raddr;
   logic                cnt_we;
   logic [CIDX_W-1:0]   cnt_waddr;
   logic [COUNT_W-1:0]  cnt_wdata;
   logic [SYMBOL_W-1:0] idx_a, idx_b;
   logic [CIDX_W-1:0]   cnt_addr;

   // Request decode.
   logic                rsp_free, accept;
   logic                load_full, load_bad, load_ok, plain_bump;
   logic [REFPOS_W-1:0] ref_ctx;
   logic [REFPOS_W:0]   ref_end;
   logic                ref_active, ref_bad, ref_ok, ref_end_ok;
   logic                rd_bad;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !rsp_free;
   assign accept = req_valid && !req_stall;

   assign load_full = (len_ff == LENCNT_W'(MAX_LEN));
   assign load_bad = (32'(req_symbol) >= 32'(symbols_in_use_ff)) ||
                     (32'(req_symbol) >= 32'(MAX_SYMBOLS));
   assign load_ok = (req_mode == MODE_LOAD) && !load_full && !load_bad;
   assign plain_bump = load_ok && !context_mode_ff && (len_ff != '0);

   assign ref_ctx = req_reference_position - REFPOS_W'(1);
   assign ref_end = (REFPOS_W + 1)'(req_reference_position) + (REFPOS_W + 1)'(shift_depth_ff);
   assign ref_active = (req_mode == MODE_REF) && context_mode_ff &&
                       (req_reference_position != '0);
   assign ref_bad = 32'(ref_ctx) >= 32'(len_ff);
   assign ref_ok = ref_active && !ref_bad;
   assign ref_end_ok = 32'(ref_end) < 32'(len_ff);

   assign rd_bad = (32'(req_row) >= 32'(MAX_SYMBOLS)) || (32'(req_col) >= 32'(MAX_SYMBOLS));

   // Flat index into the count matrix.
   assign cnt_addr = CIDX_W'(32'(idx_a) * MAX_SYMBOLS + 32'(idx_b));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CIDX_W'(CNT_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (plain_bump) state_in = ST_BUMP;
               else if (ref_ok) state_in = ST_REF1;
               else if ((req_mode == MODE_READ) && !rd_bad) state_in = ST_READ;
            end
         end
         ST_REF1: state_in = end_ok_ff ? ST_REF2 : ST_IDLE;
         ST_REF2: state_in = ST_BUMP;
         ST_BUMP: state_in = ST_IDLE;
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and response loading.
   always_comb begin
      len_in       = len_ff;
      prev_in      = prev_ff;
      ctx_pos_in   = ctx_pos_ff;
      end_addr_in  = end_addr_ff;
      end_ok_in    = end_ok_ff;
      ctx_sym_in   = ctx_sym_ff;
      clr_in       = clr_ff;
      cidx_in      = cidx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      sym_we       = 1'b0;
      sym_raddr    = LEN_W'(ref_ctx);
      cnt_we       = 1'b0;
      cnt_waddr    = cidx_ff;
      cnt_wdata    = '0;
      idx_a        = prev_ff;
      idx_b        = req_symbol;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            clr_in    = clr_ff + CIDX_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_LOAD: begin
                     if (load_full) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_result(KIND_ERROR, '0, '0, '0, ERR_FULL);
                     end else if (load_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_result(KIND_ERROR, '0, '0, '0, ERR_SYMBOL);
                     end else begin
                        sym_we  = 1'b1;
                        len_in  = len_ff + LENCNT_W'(1);
                        prev_in = req_symbol;
                        cidx_in = cnt_addr;
                        if (!context_mode_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = make_result(KIND_RECORD, req_symbol, POS_W'(len_ff),
                                                '0, ERR_NONE);
                        end
                     end
                  end
                  MODE_REF: begin
                     if (ref_active) begin
                        if (ref_bad) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = make_result(KIND_ERROR, '0, '0, '0, ERR_POSITION);
                        end else begin
                           ctx_pos_in  = LEN_W'(ref_ctx);
                           end_addr_in = LEN_W'(ref_end);
                           end_ok_in   = ref_end_ok;
                        end
                     end
                  end
                  MODE_READ: begin
                     idx_a = req_row;
                     idx_b = req_col;
                     if (rd_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_result(KIND_ERROR, '0, '0, '0, ERR_POSITION);
                     end else begin
                        cidx_in = cnt_addr;
                     end
                  end
                  MODE_RESTART: begin
                     len_in  = '0;
                     prev_in = '0;
                  end
                  default: begin
                     len_in = len_ff;
                  end
               endcase
            end
         end
         ST_REF1: begin
            // Context symbol is back; fetch the follower if it lies inside.
            ctx_sym_in = sym_rd_ff;
            sym_raddr  = end_addr_ff;
            if (!end_ok_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_result(KIND_RECORD, sym_rd_ff, POS_W'(ctx_pos_ff), '0, ERR_NONE);
            end
         end
         ST_REF2: begin
            idx_a        = ctx_sym_ff;
            idx_b        = sym_rd_ff;
            cidx_in      = cnt_addr;
            rsp_valid_in = 1'b1;
            rsp_in = make_result(KIND_RECORD, ctx_sym_ff, POS_W'(ctx_pos_ff), '0, ERR_NONE);
         end
         ST_BUMP: begin
            // Saturating increment of the fetched count.
            cnt_we    = 1'b1;
            cnt_wdata = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + COUNT_W'(1);
         end
         ST_READ: begin
            cnt_we       = 1'b1;
            cnt_wdata    = '0;
            rsp_valid_in = 1'b1;
            rsp_in       = make_result(KIND_COUNT, '0, '0, cnt_rd_ff, ERR_NONE);
         end
         default: begin
            cnt_we = 1'b0;
         end
      endcase
   end

   // Symbol memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (sym_we) sym_store[len_ff[LEN_W-1:0]] <= req_symbol;
      sym_rd_ff <= sym_store[sym_raddr];
   end

   // Count memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cnt_we) cnt_store[cnt_waddr] <= cnt_wdata;
      cnt_rd_ff <= cnt_store[cnt_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         len_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         len_ff       <= len_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ctx_pos_ff  <= ctx_pos_in;
      end_addr_ff <= end_addr_in;
      end_ok_ff   <= end_ok_in;
      ctx_sym_ff  <= ctx_sym_in;
      cidx_ff     <= cidx_in;
      rsp_ff      <= rsp_in;
   end

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         context_mode_ff   <= 1'b0;
         shift_depth_ff    <= '0;
         symbols_in_use_ff <= SYMUSE_W'(16);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CONTEXT_MODE:   context_mode_ff   <= csr_wdata[0];
            CSR_SHIFT_DEPTH:    shift_depth_ff    <= csr_wdata[SHIFT_W-1:0];
            CSR_SYMBOLS_IN_USE: symbols_in_use_ff <= csr_wdata[SYMUSE_W-1:0];
            default:            context_mode_ff   <= context_mode_ff;
         endcase
      end
   end

   // Response ports.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = rsp_ff.kind;
   assign rsp_out_symbol   = rsp_ff.symbol;
   assign rsp_out_position = rsp_ff.position;
   assign rsp_out_count    = rsp_ff.count;
   assign rsp_out_error    = rsp_ff.error;

endmodule
